/* sv/multi_mode_disk_request_scheduler_core_macros.svh */
// assertion macros for the disk request scheduler checker
// no dependencies
`ifndef MULTI_MODE_DISK_REQUEST_SCHEDULER_CORE_MACROS_SVH
`define MULTI_MODE_DISK_REQUEST_SCHEDULER_CORE_MACROS_SVH

// clocked assertion with asynchronous active-low reset
`define MDRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// payload held while a beat waits on a stalled sink
`define MDRS_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld) && !(rdy) |=> $stable(sig)) else $error(msg);

`endif

/* sv/mdrs_pkg.sv */
// shared constants and the sort-key function of the disk request scheduler
// no dependencies
package mdrs_pkg;

  localparam int unsigned MaxRequestsDefault = 32;

  localparam int unsigned CylW  = 16;
  localparam int unsigned SeekW = 22;
  localparam int unsigned KeyW  = CylW + 1;
  localparam logic [SeekW-1:0] SeekMax = '1;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_MODE       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_HEAD = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DISK_CYL   = 2'd2;

  localparam logic [2:0] MODE_FCFS  = 3'd0;
  localparam logic [2:0] MODE_SSTF  = 3'd1;
  localparam logic [2:0] MODE_SCAN  = 3'd2;
  localparam logic [2:0] MODE_CSCAN = 3'd3;
  localparam logic [2:0] MODE_LOOK  = 3'd4;
  localparam logic [2:0] MODE_CLOOK = 3'd5;

  // smaller key is served first, ties go to the earlier entry
  function automatic logic [KeyW-1:0] sched_key(input logic [2:0] mode,
                                                input logic [CylW-1:0] cyl,
                                                input logic [CylW-1:0] start,
                                                input logic [CylW-1:0] head);
    logic lo;
    logic [KeyW-1:0] k;
    lo = cyl < start;
    k  = '0;
    case (mode) inside
      MODE_SSTF: k = {1'b0, (cyl > head) ? cyl - head : head - cyl};
      MODE_SCAN, MODE_LOOK: k = {lo, lo ? ~cyl : cyl};
      MODE_CSCAN, MODE_CLOOK: k = {lo, cyl};
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

/* sv/mdrs_if.sv */
// handshake channels of the disk request scheduler
// depends on mdrs_pkg
interface mdrs_req_if;
  logic valid;
  logic ready;
  logic [mdrs_pkg::CylW-1:0] cylinder;
  logic last;
  modport source (output valid, output cylinder, output last, input ready);
  modport sink (input valid, input cylinder, input last, output ready);
endinterface

interface mdrs_res_if;
  logic valid;
  logic ready;
  logic [mdrs_pkg::CylW-1:0]  position;
  logic [mdrs_pkg::CylW-1:0]  step_distance;
  logic [mdrs_pkg::SeekW-1:0] total_seek;
  logic last_step;
  logic dropped;
  modport source (output valid, output position, output step_distance,
                  output total_seek, output last_step, output dropped, input ready);
  modport sink (input valid, input position, input step_distance,
                input total_seek, input last_step, input dropped, output ready);
endinterface

/* sv/mdrs_cell.sv */
// one request cell of the rotating store: cylinder and served flag
// depends on mdrs_pkg
module mdrs_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [mdrs_pkg::CylW-1:0] load_cyl_i,
  input  logic                      rot_i,
  input  logic [mdrs_pkg::CylW-1:0] nb_cyl_i,
  input  logic                      nb_srv_i,
  input  logic                      clr_i,
  output logic [mdrs_pkg::CylW-1:0] cyl_o,
  output logic                      srv_o
);
  logic [mdrs_pkg::CylW-1:0] cyl_q;
  logic srv_q;

  always_ff @(posedge clk_i) begin
    if (rot_i) begin
      cyl_q <= nb_cyl_i;
    end else if (load_i) begin
      cyl_q <= load_cyl_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_q <= 1'b0;
    end else if (clr_i || load_i) begin
      srv_q <= 1'b0;
    end else if (rot_i) begin
      srv_q <= nb_srv_i;
    end
  end

  assign cyl_o = cyl_q;
  assign srv_o = srv_q;
endmodule

/* sv/multi_mode_disk_request_scheduler_core.sv */
// requests load only while the core is idle; a last beat starts a run
// each result takes one full turn of the cell ring plus a decision state; top-cylinder
// and jump-to-0 moves take a decision state each, a scan sweep end one more
// a run closes with one empty turn plus a decision state; output stalls hold the decision
// a result waits in the output register while the next one is searched
// rst_ni clears the request count, flags and config registers (cylinders reset to 65535)
module multi_mode_disk_request_scheduler_core #(
  parameter int unsigned MAX_REQUESTS = mdrs_pkg::MaxRequestsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mdrs_req_if.sink                     req_i,
  mdrs_res_if.source                   res_o,
  input  logic                         cfg_we_i,
  input  logic [mdrs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mdrs_pkg::CylW-1:0]    cfg_data_i
);
  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [IW-1:0] PLast = IW'(MAX_REQUESTS - 1);
  localparam int unsigned W = mdrs_pkg::CylW;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  // config registers
  logic [2:0]   mode_q;
  logic [W-1:0] sh_q, dc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mdrs_pkg::MODE_FCFS;
      sh_q   <= '0;
      dc_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mdrs_pkg::CFG_MODE:       mode_q <= cfg_data_i[2:0];
        mdrs_pkg::CFG_START_HEAD: sh_q   <= cfg_data_i;
        mdrs_pkg::CFG_DISK_CYL:   dc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [1:0]    state_q;
  logic [CW-1:0] cnt_q, srv_n_q;
  logic          ovf_q;
  logic [2:0]    rmode_q;
  logic [W-1:0]  rs_q, top_q, head_q;
  logic [mdrs_pkg::SeekW-1:0] tot_q;
  logic          up_done_q, top_pend_q, zero_pend_q, mark_pend_q;
  logic [IW-1:0] mark_idx_q, p_q, best_idx_q;
  logic          found_q;
  logic [mdrs_pkg::KeyW-1:0] best_key_q;
  logic [W-1:0]  best_cyl_q;

  // output register
  logic          out_v_q;
  logic [W-1:0]  out_pos_q, out_dist_q;
  logic [mdrs_pkg::SeekW-1:0] out_tot_q;
  logic          out_last_q, out_drop_q;

  // cell ring
  logic [W-1:0]  cyl_w [MAX_REQUESTS];
  logic          srv_w [MAX_REQUESTS];
  logic          in_beat, run_start, rot, e_srv;

  assign in_beat   = req_i.valid && req_i.ready;
  assign run_start = in_beat && req_i.last;
  assign rot       = (state_q == ST_SCAN);
  // element at the ring head, with the previous pick marked served on its way by
  assign e_srv     = srv_w[0] || (mark_pend_q && (p_q == mark_idx_q));

  for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
    localparam int unsigned Nb = (g + 1) % MAX_REQUESTS;
    mdrs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (in_beat && (cnt_q < CW'(MAX_REQUESTS)) && (cnt_q[IW-1:0] == IW'(g))),
      .load_cyl_i (req_i.cylinder),
      .rot_i      (rot),
      .nb_cyl_i   (cyl_w[Nb]),
      .nb_srv_i   ((g == MAX_REQUESTS - 1) ? e_srv : srv_w[Nb]),
      .clr_i      (run_start),
      .cyl_o      (cyl_w[g]),
      .srv_o      (srv_w[g])
    );
  end

  // scan compare at the ring head
  logic e_ok;
  logic [mdrs_pkg::KeyW-1:0] e_key;
  assign e_ok  = (CW'(p_q) < cnt_q) && !e_srv;
  assign e_key = mdrs_pkg::sched_key(rmode_q, cyl_w[0], rs_q, head_q);

  // decision
  logic out_free, xmode, is_scan, is_cscan;
  logic emit, emit_last, to_scan, go_idle, set_up;
  logic [W-1:0] emit_pos, step_dist;
  logic [mdrs_pkg::SeekW:0] sum;
  logic rem_zero;

  assign out_free = !out_v_q || res_o.ready;
  assign is_scan  = (rmode_q == mdrs_pkg::MODE_SCAN);
  assign is_cscan = (rmode_q == mdrs_pkg::MODE_CSCAN);
  assign xmode    = is_scan || is_cscan;
  assign rem_zero = (srv_n_q + CW'(1)) == cnt_q;

  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_pos  = best_cyl_q;
    to_scan   = 1'b0;
    go_idle   = 1'b0;
    set_up    = 1'b0;
    if (state_q == ST_DECIDE && out_free) begin
      if (xmode && !up_done_q && (!found_q || best_key_q[mdrs_pkg::KeyW-1])) begin
        // upward sweep finished
        set_up = 1'b1;
      end else if (top_pend_q) begin
        emit      = 1'b1;
        emit_pos  = top_q;
        emit_last = (srv_n_q == cnt_q) && !zero_pend_q;
      end else if (zero_pend_q) begin
        emit      = 1'b1;
        emit_pos  = '0;
        emit_last = (srv_n_q == cnt_q);
      end else if (found_q) begin
        emit      = 1'b1;
        to_scan   = 1'b1;
        // a pending upward-sweep end still adds moves after the last request
        emit_last = rem_zero &&
                    !(xmode && !up_done_q && (is_cscan || (best_cyl_q < top_q)));
      end else begin
        go_idle = 1'b1;
      end
    end
  end

  assign step_dist = (emit_pos > head_q) ? emit_pos - head_q : head_q - emit_pos;
  assign sum       = {1'b0, tot_q} + (mdrs_pkg::SeekW + 1)'(step_dist);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      srv_n_q     <= '0;
      ovf_q       <= 1'b0;
      rmode_q     <= mdrs_pkg::MODE_FCFS;
      up_done_q   <= 1'b0;
      top_pend_q  <= 1'b0;
      zero_pend_q <= 1'b0;
      mark_pend_q <= 1'b0;
      found_q     <= 1'b0;
      p_q         <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (res_o.ready && !emit) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            if (cnt_q < CW'(MAX_REQUESTS)) begin
              cnt_q <= cnt_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (req_i.last) begin
              rmode_q     <= mode_q;
              srv_n_q     <= '0;
              up_done_q   <= 1'b0;
              top_pend_q  <= 1'b0;
              zero_pend_q <= 1'b0;
              mark_pend_q <= 1'b0;
              found_q     <= 1'b0;
              p_q         <= '0;
              state_q     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (e_ok && (!found_q || e_key < best_key_q)) begin
            found_q <= 1'b1;
          end
          if (p_q == PLast) begin
            p_q         <= '0;
            mark_pend_q <= 1'b0;
            state_q     <= ST_DECIDE;
          end else begin
            p_q <= p_q + IW'(1);
          end
        end
        ST_DECIDE: begin
          if (set_up) begin
            up_done_q   <= 1'b1;
            top_pend_q  <= head_q < top_q;
            zero_pend_q <= is_cscan;
          end
          if (emit) begin
            out_v_q <= 1'b1;
            if (top_pend_q) begin
              top_pend_q <= 1'b0;
            end else if (zero_pend_q) begin
              zero_pend_q <= 1'b0;
            end
          end
          if (to_scan) begin
            srv_n_q     <= srv_n_q + CW'(1);
            mark_pend_q <= 1'b1;
            found_q     <= 1'b0;
            state_q     <= ST_SCAN;
          end
          if (go_idle) begin
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (run_start) begin
      rs_q   <= sh_q;
      head_q <= sh_q;
      top_q  <= (dc_q == '0) ? '0 : dc_q - W'(1);
      tot_q  <= '0;
    end
    if (state_q == ST_SCAN && e_ok && (!found_q || e_key < best_key_q)) begin
      best_key_q <= e_key;
      best_idx_q <= p_q;
      best_cyl_q <= cyl_w[0];
    end
    if (to_scan) begin
      mark_idx_q <= best_idx_q;
    end
    if (emit) begin
      head_q     <= emit_pos;
      tot_q      <= sum[mdrs_pkg::SeekW] ? mdrs_pkg::SeekMax : sum[mdrs_pkg::SeekW-1:0];
      out_pos_q  <= emit_pos;
      out_dist_q <= step_dist;
      out_tot_q  <= sum[mdrs_pkg::SeekW] ? mdrs_pkg::SeekMax : sum[mdrs_pkg::SeekW-1:0];
      out_last_q <= emit_last;
      out_drop_q <= ovf_q;
    end
  end

  assign req_i.ready         = (state_q == ST_IDLE);
  assign res_o.valid         = out_v_q;
  assign res_o.position      = out_pos_q;
  assign res_o.step_distance = out_dist_q;
  assign res_o.total_seek    = out_tot_q;
  assign res_o.last_step     = out_last_q;
  assign res_o.dropped       = out_drop_q;
endmodule

/* sv/mdrs_checker.sv */
// port-level checks of the disk request scheduler, bound to the top level
// depends on mdrs_pkg and the macros header
`include "multi_mode_disk_request_scheduler_core_macros.svh"

module mdrs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [mdrs_pkg::CylW-1:0]     out_pos_i,
  input logic [mdrs_pkg::CylW-1:0]     out_dist_i,
  input logic [mdrs_pkg::SeekW-1:0]    out_tot_i,
  input logic                          out_last_i
);
  `MDRS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result beat dropped")
  `MDRS_ASSERT_HOLD(a_out_stable, clk_i, rst_ni, out_valid_i, out_ready_i, out_pos_i, "stalled result changed")
  `MDRS_ASSERT(a_busy_mid_run, clk_i, rst_ni, out_valid_i && !out_last_i |-> !in_ready_i, "input taken mid run")
  `MDRS_ASSERT(a_seek_sum, clk_i, rst_ni, out_valid_i |-> ({6'd0, out_dist_i} <= out_tot_i), "total below step")
endmodule

bind multi_mode_disk_request_scheduler_core mdrs_checker u_mdrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_pos_i   (res_o.position),
  .out_dist_i  (res_o.step_distance),
  .out_tot_i   (res_o.total_seek),
  .out_last_i  (res_o.last_step)
);

/* tb/tb_multi_mode_disk_request_scheduler_core.sv */
// self-checking bench for the multi-mode disk request scheduler core
// depends on mdrs_pkg, mdrs_if and the core; predicts every head move of every run
`timescale 1ns / 1ps

module tb_multi_mode_disk_request_scheduler_core;
  import mdrs_pkg::*;

  localparam int unsigned Depth = MaxRequestsDefault;

  typedef struct packed {
    logic [CylW-1:0]  position;
    logic [CylW-1:0]  step_distance;
    logic [SeekW-1:0] total_seek;
    logic             last_step;
    logic             dropped;
  } move_t;

  // one directed row: register setup, request beat, optional typed-in first move
  typedef struct {
    logic             set_cfg;
    logic [2:0]       mode;
    logic [CylW-1:0]  start;
    logic [CylW-1:0]  cyls;
    logic [CylW-1:0]  cylinder;
    logic             last;
    logic             has_first;
    move_t            first;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CylW-1:0] cfg_data_i;

  mdrs_req_if req_if ();
  mdrs_res_if res_if ();

  multi_mode_disk_request_scheduler_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if.sink),
    .res_o      (res_if.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  logic [2:0]      pm_mode;
  logic [CylW-1:0] pm_start;
  logic [CylW-1:0] pm_cyls;
  logic [CylW-1:0] pm_store [Depth];
  int unsigned     pm_count;
  logic            pm_overflow;
  logic [CylW-1:0] pm_head;
  logic [SeekW-1:0] pm_seek;

  move_t pending_moves[$];
  move_t row_first_q[$];
  int    error_count;
  bit    quiet_mode;
  int    row_pending;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // append one head move to the expected stream
  task automatic push_move(input logic [CylW-1:0] target);
    logic [CylW-1:0] step_dist;
    logic [SeekW:0] sum;
    move_t m;
    step_dist = (target > pm_head) ? target - pm_head : pm_head - target;
    sum = {1'b0, pm_seek} + (SeekW + 1)'(step_dist);
    pm_seek = (sum > SeekMax) ? SeekMax : sum[SeekW-1:0];
    pm_head = target;
    m.position = target;
    m.step_distance = step_dist;
    m.total_seek = pm_seek;
    m.last_step = 1'b0;
    m.dropped = pm_overflow;
    pending_moves.push_back(m);
  endtask

  // service order of one batch
  task automatic serve_batch();
    logic [CylW-1:0] lo[$];
    logic [CylW-1:0] hi[$];
    logic [CylW-1:0] top;
    bit served [Depth];
    int before_n;
    int best;
    logic [CylW-1:0] bestd;
    logic [CylW-1:0] d;
    bit found;
    move_t m;
    before_n = pending_moves.size();
    top = (pm_cyls == 0) ? '0 : pm_cyls - 1'b1;
    pm_head = pm_start;
    pm_seek = '0;
    for (int i = 0; i < Depth; i++) served[i] = 1'b0;
    for (int i = 0; i < pm_count; i++) begin
      if (pm_store[i] < pm_start) lo.push_back(pm_store[i]);
      else hi.push_back(pm_store[i]);
    end
    lo.sort();
    hi.sort();
    case (pm_mode)
      MODE_SSTF: begin
        for (int k = 0; k < pm_count; k++) begin
          best = 0;
          bestd = '1;
          found = 1'b0;
          for (int i = 0; i < pm_count; i++) begin
            d = (pm_store[i] > pm_head) ? pm_store[i] - pm_head : pm_head - pm_store[i];
            if (!served[i] && (!found || d < bestd)) begin
              bestd = d;
              best = i;
              found = 1'b1;
            end
          end
          served[best] = 1'b1;
          push_move(pm_store[best]);
        end
      end
      MODE_SCAN, MODE_CSCAN: begin
        foreach (hi[i]) push_move(hi[i]);
        if (pm_head < top) push_move(top);
        if (pm_mode == MODE_SCAN) begin
          for (int i = lo.size() - 1; i >= 0; i--) push_move(lo[i]);
        end else begin
          push_move('0);
          foreach (lo[i]) push_move(lo[i]);
        end
      end
      MODE_LOOK: begin
        foreach (hi[i]) push_move(hi[i]);
        for (int i = lo.size() - 1; i >= 0; i--) push_move(lo[i]);
      end
      MODE_CLOOK: begin
        foreach (hi[i]) push_move(hi[i]);
        foreach (lo[i]) push_move(lo[i]);
      end
      default: begin
        for (int i = 0; i < pm_count; i++) push_move(pm_store[i]);
      end
    endcase
    if (pending_moves.size() > before_n) begin
      m = pending_moves[$];
      m.last_step = 1'b1;
      pending_moves[pending_moves.size() - 1] = m;
    end
    pm_count = 0;
    pm_overflow = 1'b0;
  endtask

  task automatic predict_request(input logic [CylW-1:0] cyl, input logic last);
    if (pm_count < Depth) begin
      pm_store[pm_count] = cyl;
      pm_count++;
    end else begin
      pm_overflow = 1'b1;
    end
    if (last) serve_batch();
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CylW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MODE: pm_mode = val[2:0];
      CFG_START_HEAD: pm_start = val;
      default: pm_cyls = val;
    endcase
  endtask

  // close the request stream, drain all results, then wait out any search still running
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_moves.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (Depth * 3) @(negedge clk_i);
  endtask

  task automatic set_all(input logic [2:0] md, input logic [CylW-1:0] st,
                         input logic [CylW-1:0] cy);
    settle();
    write_reg(CFG_MODE, {13'd0, md});
    write_reg(CFG_START_HEAD, st);
    write_reg(CFG_DISK_CYL, cy);
  endtask

  // one request beat with optional random gap before it; returns at the accepting edge
  task automatic send_request(input logic [CylW-1:0] cyl, input logic last);
    @(negedge clk_i);
    while (!quiet_mode && $urandom_range(99) < 27) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cylinder <= cyl;
    req_if.last <= last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_request(cyl, last);
  endtask

  // result side: random stalls, compare against oldest expectation
  always @(negedge clk_i) begin
    if (rst_ni) res_if.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 27);
  end

  always @(posedge clk_i) begin
    move_t exp_m;
    move_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.position = res_if.position;
      got.step_distance = res_if.step_distance;
      got.total_seek = res_if.total_seek;
      got.last_step = res_if.last_step;
      got.dropped = res_if.dropped;
      if (pending_moves.size() == 0) begin
        $display("%0t: unexpected move, expected none, actual %p", $time, got);
        error_count++;
      end else begin
        exp_m = pending_moves.pop_front();
        if (got !== exp_m) begin
          $display("%0t: move mismatch, expected %p, actual %p", $time, exp_m, got);
          error_count++;
        end
        // rows with a hand-typed first move are cross-checked too
        if (row_first_q.size() != 0 && row_pending != 0) begin
          exp_m = row_first_q.pop_front();
          row_pending--;
          if (got !== exp_m) begin
            $display("%0t: directed move mismatch, expected %p, actual %p",
                     $time, exp_m, got);
            error_count++;
          end
        end
      end
    end
  end

  function automatic move_t mk(input logic [CylW-1:0] p, input logic [CylW-1:0] d,
                               input logic [SeekW-1:0] s, input logic ls,
                               input logic dr);
    move_t m;
    m.position = p;
    m.step_distance = d;
    m.total_seek = s;
    m.last_step = ls;
    m.dropped = dr;
    return m;
  endfunction

  function automatic row_t mkrow(input logic sc, input logic [2:0] md,
                                 input logic [CylW-1:0] st, input logic [CylW-1:0] cy,
                                 input logic [CylW-1:0] c, input logic l,
                                 input logic hf, input move_t f);
    row_t r;
    r.set_cfg = sc;
    r.mode = md;
    r.start = st;
    r.cyls = cy;
    r.cylinder = c;
    r.last = l;
    r.has_first = hf;
    r.first = f;
    return r;
  endfunction

  // random batch; mostly small, a few fill or overflow the store
  task automatic random_batch(output int sent);
    int n;
    int pick;
    logic [CylW-1:0] c;
    pick = $urandom_range(99);
    if (pick < 6) n = Depth + $urandom_range(3);
    else if (pick < 12) n = 1;
    else n = 2 + $urandom_range(7);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: c = CylW'($urandom);
        1: c = CylW'(pm_start + $urandom_range(3) - 1);
        2: c = CylW'($urandom_range(255));
        default: c = CylW'(16'hFFFF - $urandom_range(255));
      endcase
      send_request(c, i == n - 1);
    end
    sent = n;
  endtask

  initial begin
    row_t rows[$];
    move_t z;
    int sent;
    int total;
    z = '0;
    error_count = 0;
    quiet_mode = 1'b0;
    row_pending = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MODE;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.cylinder = '0;
    req_if.last = 1'b0;
    res_if.ready = 1'b0;
    pm_mode = MODE_FCFS;
    pm_start = '0;
    pm_cyls = 16'hFFFF;
    pm_count = 0;
    pm_overflow = 1'b0;
    pm_head = '0;
    pm_seek = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset: fcfs from cylinder 0
    rows.push_back(mkrow(1'b0, MODE_FCFS, 16'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1,
                         mk(16'hFFFF, 16'hFFFF, 22'd65535, 1'b1, 1'b0)));
    rows.push_back(mkrow(1'b1, MODE_SSTF, 16'd100, 16'hFFFF, 16'd110, 1'b0, 1'b1,
                         mk(16'd98, 16'd2, 22'd2, 1'b0, 1'b0)));
    rows.push_back(mkrow(1'b0, MODE_SSTF, 16'd100, 16'hFFFF, 16'd98, 1'b0, 1'b0, z));
    rows.push_back(mkrow(1'b0, MODE_SSTF, 16'd100, 16'hFFFF, 16'd102, 1'b1, 1'b0, z));
    // scan toward the top cylinder
    rows.push_back(mkrow(1'b1, MODE_SCAN, 16'd50, 16'd200, 16'd60, 1'b0, 1'b1,
                         mk(16'd60, 16'd10, 22'd10, 1'b0, 1'b0)));
    rows.push_back(mkrow(1'b0, MODE_SCAN, 16'd50, 16'd200, 16'd10, 1'b1, 1'b0, z));
    rows.push_back(mkrow(1'b1, MODE_CSCAN, 16'd50, 16'd200, 16'd40, 1'b1, 1'b1,
                         mk(16'd199, 16'd149, 22'd149, 1'b0, 1'b0)));
    rows.push_back(mkrow(1'b1, MODE_LOOK, 16'd50, 16'd200, 16'd50, 1'b0, 1'b1,
                         mk(16'd50, 16'd0, 22'd0, 1'b0, 1'b0)));
    rows.push_back(mkrow(1'b0, MODE_LOOK, 16'd50, 16'd200, 16'd20, 1'b1, 1'b0, z));
    // c-look with no request below the start head: no wrap
    rows.push_back(mkrow(1'b1, MODE_CLOOK, 16'd50, 16'd200, 16'd70, 1'b1, 1'b1,
                         mk(16'd70, 16'd20, 22'd20, 1'b1, 1'b0)));
    rows.push_back(mkrow(1'b1, MODE_CLOOK, 16'd50, 16'd200, 16'd30, 1'b0, 1'b0, z));
    rows.push_back(mkrow(1'b0, MODE_CLOOK, 16'd50, 16'd200, 16'd90, 1'b1, 1'b0, z));
    // unused mode falls back to fcfs; zero cylinders; request above top
    rows.push_back(mkrow(1'b1, 3'd7, 16'd0, 16'd0, 16'd500, 1'b1, 1'b1,
                         mk(16'd500, 16'd500, 22'd500, 1'b1, 1'b0)));
    rows.push_back(mkrow(1'b1, MODE_SCAN, 16'hFFFF, 16'd1, 16'd0, 1'b1, 1'b0, z));
    rows.push_back(mkrow(1'b1, MODE_CSCAN, 16'd0, 16'hFFFF, 16'd0, 1'b1, 1'b0, z));

    foreach (rows[i]) begin
      if (rows[i].set_cfg) set_all(rows[i].mode, rows[i].start, rows[i].cyls);
      if (rows[i].has_first) begin
        row_first_q.push_back(rows[i].first);
        row_pending++;
      end
      send_request(rows[i].cylinder, rows[i].last);
    end
    settle();
    // overflow: a full store plus two dropped beats, last one dropped too
    set_all(MODE_FCFS, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < Depth + 2; i++) send_request(CylW'(16'hFFFF - i), i == Depth + 1);

    total = 0;
    while (total < 210) begin
      settle();
      if ($urandom_range(3) == 0) begin
        set_all(3'($urandom_range(7)), CylW'($urandom),
                $urandom_range(1) ? CylW'($urandom) : 16'hFFFF);
      end else if ($urandom_range(1)) begin
        write_reg(CFG_MODE, CylW'($urandom_range(5)));
      end
      quiet_mode = (total > 90 && total < 130);
      random_batch(sent);
      total += sent;
    end
    quiet_mode = 1'b0;
    settle();
    if (pending_moves.size() != 0 || row_first_q.size() != 0) begin
      $display("%0t: moves missing, expected %0d more, actual 0",
               $time, pending_moves.size() + row_first_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
